/* src/ptcr_pkg.sv */
// Shared types, constants and the arctangent table of the phase-to-complex pipeline.
package ptcr_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int STAGE_W = 5;
	localparam int XY_W = 34;
	localparam int Z_W = 34;
	localparam int T_W = 38;
	localparam int OUT_W = 48;
	localparam int REG_W = 32;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_RECIP_RADIUS = 1'b1;

	localparam logic [REG_W-1:0] RADIUS_RESET = 32'd65536;
	localparam logic [REG_W-1:0] RECIP_RESET = 32'd268435456;

	localparam logic signed [T_W-1:0] PI_Q30 = 38'sd3373259426;
	localparam logic signed [T_W-1:0] TWO_PI_Q30 = 38'sd6746518852;
	localparam logic signed [T_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
	localparam logic signed [XY_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

	// Data carried from one rotation cell to the next.
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic flip;
		logic signed [31:0] w;
	} ptcr_cordic_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [STAGE_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

/* src/phase_to_complex_with_rate_top.sv */
// Top level: config registers, angle reduction, CORDIC cell row and output scaling.
// Throughput: one word per cycle; the whole pipeline advances unless a held output is stalled.
// in_stall is high exactly while a finished output word is waiting under out_stall.
// Reset clears all valid flags; radius and recip_radius reset to 1.0.
module phase_to_complex_with_rate_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] theta,
	input  logic signed [31:0] theta_rate,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ptcr_pkg::OUT_W-1:0] phi_re,
	output logic signed [ptcr_pkg::OUT_W-1:0] phi_im,
	output logic signed [ptcr_pkg::OUT_W-1:0] rate_re,
	output logic signed [ptcr_pkg::OUT_W-1:0] rate_im,
	input  logic cfg_wr_en,
	input  logic cfg_index,
	input  logic [ptcr_pkg::REG_W-1:0] cfg_data
);
	import ptcr_pkg::*;

	logic en;
	logic [REG_W-1:0] radius_q;
	logic [REG_W-1:0] recip_q;
	logic cell_v [0:CORDIC_STAGES];
	ptcr_cordic_t cell_d [0:CORDIC_STAGES];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			recip_q <= RECIP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_RECIP_RADIUS: recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptcr_reduce u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_ok(in_valid),
		.theta(theta),
		.theta_rate(theta_rate),
		.valid_s2(cell_v[0]),
		.data_s2(cell_d[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		ptcr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.stage(STAGE_W'(g)),
			.valid_d(cell_v[g]),
			.data_d(cell_d[g]),
			.valid_q(cell_v[g+1]),
			.data_q(cell_d[g+1])
		);
	end

	ptcr_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_d(cell_v[CORDIC_STAGES]),
		.data_d(cell_d[CORDIC_STAGES]),
		.radius(radius_q),
		.recip_radius(recip_q),
		.out_valid(out_valid),
		.phi_re(phi_re),
		.phi_im(phi_im),
		.rate_re(rate_re),
		.rate_im(rate_im)
	);

endmodule

/* src/ptcr_reduce.sv */
// Angle reduction to [-pi/2, pi/2] with quadrant fold, two pipeline stages.
module ptcr_reduce (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_ok,
	input  logic signed [31:0] theta,
	input  logic signed [31:0] theta_rate,
	output logic valid_s2,
	output ptcr_pkg::ptcr_cordic_t data_s2
);
	import ptcr_pkg::*;

	logic signed [T_W-1:0] t;
	logic signed [T_W-1:0] a;
	logic signed [T_W-1:0] thr;
	logic [3:0] q_cnt;
	logic [3:0] q_cnt_s1;
	logic signed [T_W-1:0] t_s1;
	logic signed [31:0] w_s1;
	logic valid_s1;
	logic signed [T_W-1:0] q_off;
	logic signed [T_W-1:0] z_full;
	logic signed [T_W-1:0] z_fold;
	logic flip;
	ptcr_cordic_t d_next;

	// The reduced turn count q lies in [-6, 5]; it is -6 plus the number of
	// thresholds k*2pi at or below theta+pi.
	always_comb begin
		t = {{2{theta[31]}}, theta, 4'b0000};
		a = t + PI_Q30;
		q_cnt = '0;
		thr = '0;
		for (int k = -5; k <= 5; k++) begin
			thr = T_W'(k) * TWO_PI_Q30;
			q_cnt = q_cnt + {3'b000, (a >= thr)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_cnt_s1 <= q_cnt;
			t_s1 <= t;
			w_s1 <= theta_rate;
		end
	end

	always_comb begin
		q_off = ($signed({1'b0, q_cnt_s1}) - T_W'(6)) * TWO_PI_Q30;
		z_full = t_s1 - q_off;
		flip = 1'b0;
		z_fold = z_full;
		if (z_full > HALF_PI_Q30) begin
			z_fold = z_full - PI_Q30;
			flip = 1'b1;
		end else if (z_full < -HALF_PI_Q30) begin
			z_fold = z_full + PI_Q30;
			flip = 1'b1;
		end
		d_next.x = CORDIC_K_Q30;
		d_next.y = '0;
		d_next.z = z_fold[Z_W-1:0];
		d_next.flip = flip;
		d_next.w = w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= d_next;
		end
	end

endmodule

/* src/ptcr_cell.sv */
// One CORDIC rotation cell: a single micro-rotation followed by a register.
module ptcr_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [ptcr_pkg::STAGE_W-1:0] stage,
	input  logic valid_d,
	input  ptcr_pkg::ptcr_cordic_t data_d,
	output logic valid_q,
	output ptcr_pkg::ptcr_cordic_t data_q
);
	import ptcr_pkg::*;

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0] at;
	ptcr_cordic_t nxt;

	always_comb begin
		dx = data_d.y >>> stage;
		dy = data_d.x >>> stage;
		at = atan_q30(stage);
		nxt = data_d;
		if (!data_d.z[Z_W-1]) begin
			nxt.x = data_d.x - dx;
			nxt.y = data_d.y + dy;
			nxt.z = data_d.z - at;
		end else begin
			nxt.x = data_d.x + dx;
			nxt.y = data_d.y - dy;
			nxt.z = data_d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

/* src/ptcr_scale.sv */
// Radius scaling, rate products, rounding and saturation, ending in the output register.
module ptcr_scale (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_d,
	input  ptcr_pkg::ptcr_cordic_t data_d,
	input  logic [ptcr_pkg::REG_W-1:0] radius,
	input  logic [ptcr_pkg::REG_W-1:0] recip_radius,
	output logic out_valid,
	output logic signed [ptcr_pkg::OUT_W-1:0] phi_re,
	output logic signed [ptcr_pkg::OUT_W-1:0] phi_im,
	output logic signed [ptcr_pkg::OUT_W-1:0] rate_re,
	output logic signed [ptcr_pkg::OUT_W-1:0] rate_im
);
	import ptcr_pkg::*;

	localparam int PW = 82;
	localparam int SW = 85;

	logic signed [XY_W:0] c;
	logic signed [XY_W:0] s;
	logic signed [XY_W+REG_W+1:0] pc;
	logic signed [XY_W+REG_W+1:0] ps;
	logic signed [XY_W+REG_W+1:0] pc_r;
	logic signed [XY_W+REG_W+1:0] ps_r;
	logic signed [OUT_W-1:0] pre_s1, pim_s1, pre_s2, pim_s2, pre_s3, pim_s3;
	logic signed [31:0] w_s1;
	logic valid_s1, valid_s2, valid_s3;
	logic signed [23:0] re_hi, im_hi;
	logic signed [24:0] re_lo, im_lo;
	logic signed [REG_W:0] rec_s;
	logic signed [57:0] re_rec_lo_s2, im_rec_lo_s2;
	logic signed [56:0] re_rec_hi_s2, im_rec_hi_s2;
	logic signed [56:0] re_w_lo_s2, im_w_lo_s2;
	logic signed [55:0] re_w_hi_s2, im_w_hi_s2;
	logic signed [PW-1:0] p_re_rec_s3, p_im_rec_s3, p_re_w_s3, p_im_w_s3;
	logic signed [SW-1:0] rr, ri, rr_r, ri_r;

	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
		lo = -SW'(64'sd1 <<< (OUT_W - 1));
		if (v > hi) begin
			return hi[OUT_W-1:0];
		end else if (v < lo) begin
			return lo[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

	// Stage 1: radius times cos and sin, rounded from Q46 to Q24.
	always_comb begin
		c = data_d.flip ? -(XY_W+1)'(data_d.x) : (XY_W+1)'(data_d.x);
		s = data_d.flip ? -(XY_W+1)'(data_d.y) : (XY_W+1)'(data_d.y);
		pc = $signed({1'b0, radius}) * c;
		ps = $signed({1'b0, radius}) * s;
		pc_r = (pc + (XY_W+REG_W+2)'(64'sd1 <<< 21)) >>> 22;
		ps_r = (ps + (XY_W+REG_W+2)'(64'sd1 <<< 21)) >>> 22;
	end

	// Each phase word is split into a signed upper and an unsigned lower 24-bit half
	// so that every product stays narrow; the halves are joined into the _s3 products.
	always_comb begin
		re_hi = pre_s1[OUT_W-1:24];
		im_hi = pim_s1[OUT_W-1:24];
		re_lo = $signed({1'b0, pre_s1[23:0]});
		im_lo = $signed({1'b0, pim_s1[23:0]});
		rec_s = $signed({1'b0, recip_radius});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_d;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pc_r[OUT_W-1:0];
			pim_s1 <= ps_r[OUT_W-1:0];
			w_s1 <= data_d.w;
			pre_s2 <= pre_s1;
			pim_s2 <= pim_s1;
			re_rec_lo_s2 <= re_lo * rec_s;
			re_rec_hi_s2 <= re_hi * rec_s;
			im_rec_lo_s2 <= im_lo * rec_s;
			im_rec_hi_s2 <= im_hi * rec_s;
			re_w_lo_s2 <= re_lo * w_s1;
			re_w_hi_s2 <= re_hi * w_s1;
			im_w_lo_s2 <= im_lo * w_s1;
			im_w_hi_s2 <= im_hi * w_s1;
			pre_s3 <= pre_s2;
			pim_s3 <= pim_s2;
			p_re_rec_s3 <= (PW'(re_rec_hi_s2) <<< 24) + PW'(re_rec_lo_s2);
			p_im_rec_s3 <= (PW'(im_rec_hi_s2) <<< 24) + PW'(im_rec_lo_s2);
			p_re_w_s3 <= (PW'(re_w_hi_s2) <<< 24) + PW'(re_w_lo_s2);
			p_im_w_s3 <= (PW'(im_w_hi_s2) <<< 24) + PW'(im_w_lo_s2);
		end
	end

	// The theta_rate products are Q50 and move up to Q52 before the sum.
	always_comb begin
		rr = SW'(p_re_rec_s3) - (SW'(p_im_w_s3) <<< 2);
		ri = SW'(p_im_rec_s3) + (SW'(p_re_w_s3) <<< 2);
		rr_r = (rr + SW'(64'sd1 <<< 27)) >>> 28;
		ri_r = (ri + SW'(64'sd1 <<< 27)) >>> 28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_re <= pre_s3;
			phi_im <= pim_s3;
			rate_re <= sat48(rr_r);
			rate_im <= sat48(ri_r);
		end
	end

endmodule

/* src/ptcr_checker.sv */
// Port-level checks on the top level and their bind.
module ptcr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [ptcr_pkg::OUT_W-1:0] phi_re,
	input logic signed [ptcr_pkg::OUT_W-1:0] phi_im
);
	import ptcr_pkg::*;

	// Input is held back only by an output word that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting output word");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while output word is held");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// The phase outputs never take the most negative 48-bit value.
	a_phi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phi_re != {1'b1, {(OUT_W-1){1'b0}}}
			&& phi_im != {1'b1, {(OUT_W-1){1'b0}}}))
		else $error("phase output at negative limit");

endmodule

bind phase_to_complex_with_rate_top ptcr_checker u_ptcr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.phi_re(phi_re),
	.phi_im(phi_im)
);

/* test/tb_phase_to_complex_with_rate_top.sv */
// Testbench for the phase-to-complex pipeline: random and directed words checked against a predictor.
module tb_phase_to_complex_with_rate_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ptcr_pkg::*;

	typedef struct {
		logic signed [47:0] phi_re;
		logic signed [47:0] phi_im;
		logic signed [47:0] rate_re;
		logic signed [47:0] rate_im;
	} phasor_t;

	// Predicts each output word from the current register values and compares results in order.
	class phasor_scoreboard;
		logic [31:0] radius_q16;
		logic [31:0] recip_q28;
		phasor_t pending[$];
		int errors;

		function new();
			radius_q16 = RADIUS_RESET;
			recip_q28 = RECIP_RESET;
			errors = 0;
		endfunction

		function automatic logic signed [47:0] round_to_q24(logic signed [127:0] v);
			logic signed [127:0] r;
			r = (v + (128'sd1 <<< 27)) >>> 28;
			if (r > 128'sd140737488355327) return 48'sh7FFFFFFFFFFF;
			if (r < -128'sd140737488355328) return 48'sh800000000000;
			return r[47:0];
		endfunction

		function void note_input(logic signed [31:0] th, logic signed [31:0] rate);
			logic signed [63:0] t, a, q, z, x, y, dx, dy, c, s, pre, pim, atn;
			logic signed [127:0] rr, ri, rad, rec, w;
			logic flip;
			phasor_t e;
			t = 64'(th) * 16;
			a = t + 64'(PI_Q30);
			q = a / 64'(TWO_PI_Q30);
			if (a % 64'(TWO_PI_Q30) < 0) q = q - 1;
			z = t - q * 64'(TWO_PI_Q30);
			flip = 1'b0;
			if (z > 64'(HALF_PI_Q30)) begin
				z = z - 64'(PI_Q30);
				flip = 1'b1;
			end else if (z < -64'(HALF_PI_Q30)) begin
				z = z + 64'(PI_Q30);
				flip = 1'b1;
			end
			x = 64'(CORDIC_K_Q30);
			y = 0;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				atn = 64'(atan_q30(i[4:0]));
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atn;
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atn;
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			pre = ($signed({32'd0, radius_q16}) * c + (64'sd1 <<< 21)) >>> 22;
			pim = ($signed({32'd0, radius_q16}) * s + (64'sd1 <<< 21)) >>> 22;
			rec = $signed({96'd0, recip_q28});
			w = 128'(rate);
			rr = 128'(pre) * rec - ((128'(pim) * w) <<< 2);
			ri = 128'(pim) * rec + ((128'(pre) * w) <<< 2);
			e.phi_re = pre[47:0];
			e.phi_im = pim[47:0];
			e.rate_re = round_to_q24(rr);
			e.rate_im = round_to_q24(ri);
			pending.push_back(e);
		endfunction

		function void check_result(phasor_t got);
			phasor_t e;
			if (pending.size() == 0) begin
				$error("output word with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.phi_re !== e.phi_re) begin
				$error("phi_re expected %0d actual %0d", e.phi_re, got.phi_re);
				errors++;
			end
			if (got.phi_im !== e.phi_im) begin
				$error("phi_im expected %0d actual %0d", e.phi_im, got.phi_im);
				errors++;
			end
			if (got.rate_re !== e.rate_re) begin
				$error("rate_re expected %0d actual %0d", e.rate_re, got.rate_re);
				errors++;
			end
			if (got.rate_im !== e.rate_im) begin
				$error("rate_im expected %0d actual %0d", e.rate_im, got.rate_im);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = CORDIC_STAGES + 6;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] theta, theta_rate;
	logic signed [OUT_W-1:0] phi_re, phi_im, rate_re, rate_im;
	logic cfg_wr_en, cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic stall_enable;
	int idle_cycles;
	phasor_scoreboard board;

	phase_to_complex_with_rate_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// The valid line stays high after a word so that a following word can go back to back.
	task automatic send_word(logic [31:0] th, logic [31:0] rate, bit gaps);
		int g;
		g = gaps ? gap_length() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		theta <= th;
		theta_rate <= rate;
		board.note_input(th, rate);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_RADIUS) board.radius_q16 = value;
		else board.recip_q28 = value;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_angle();
		case ($urandom_range(0, 5))
			0: return 32'h80000000 + $urandom_range(0, 15);
			1: return 32'h7FFFFFFF - $urandom_range(0, 15);
			2: return $urandom_range(0, 31) - 16;
			default: return $urandom();
		endcase
	endfunction

	// Result side: random stalls, check each accepted word.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_result('{phi_re, phi_im, rate_re, rate_im});
		out_stall <= stall_enable && ($urandom_range(0, 3) == 0 ||
			($urandom_range(0, 60) == 0));
	end

	// Watchdog on cycles where no word moves on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("phase_to_complex_with_rate_top: mismatch");
			$finish;
		end
	end

	initial begin
		logic [31:0] radius_set[6];
		logic [31:0] recip_set[6];
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		theta = '0;
		theta_rate = '0;
		cfg_wr_en = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		stall_enable = 1'b0;
		idle_cycles = 0;
		radius_set = '{32'd65536, 32'hFFFFFFFF, 32'd0, 32'd1, 32'h00200000, 32'h00004000};
		recip_set = '{32'd268435456, 32'hFFFFFFFF, 32'd0, 32'd1, 32'h00800000, 32'h40000000};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset register values: field extremes and quadrant edges.
		send_word(32'h00000000, 32'h00000000, 0);
		send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_word(32'h80000000, 32'h80000000, 0);
		send_word(32'h7FFFFFFF, 32'h80000000, 0);
		send_word(32'h80000000, 32'h7FFFFFFF, 0);
		send_word(32'h06487ED5, 32'h04000000, 0);
		send_word(32'hF9B7812B, 32'hFC000000, 0);
		send_word(32'h0C90FDAA, 32'h00000001, 0);
		send_word(32'hF36F0256, 32'hFFFFFFFF, 0);
		send_word(32'h1921FB54, 32'h55555555, 0);
		send_word(32'hE6DE04AC, 32'hAAAAAAAA, 0);
		send_word(32'h12D97C7F, 32'h00000000, 0);
		drain();

		// Extreme and inconsistent register settings, with saturating rates.
		write_reg(REG_RADIUS, 32'hFFFFFFFF);
		write_reg(REG_RECIP_RADIUS, 32'hFFFFFFFF);
		send_word(32'h00000000, 32'h7FFFFFFF, 0);
		send_word(32'h0C90FDAA, 32'h80000000, 0);
		send_word(32'h3243F6A8, 32'h7FFFFFFF, 0);
		send_word(32'h12D97C7F, 32'h80000000, 0);
		drain();
		write_reg(REG_RADIUS, 32'd0);
		write_reg(REG_RECIP_RADIUS, 32'd0);
		send_word(32'h12345678, 32'h7FFFFFFF, 0);
		send_word(32'h80000000, 32'h80000000, 0);
		drain();

		// Random phases, each with its own register setting.
		stall_enable = 1'b1;
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_RADIUS, p == 5 ? $urandom() : radius_set[p]);
			write_reg(REG_RECIP_RADIUS, p == 5 ? $urandom() : recip_set[p]);
			for (int n = 0; n < 155; n++)
				send_word(random_angle(), $urandom_range(0, 4) == 0 ? random_angle()
					: $urandom(), p != 2);
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("phase_to_complex_with_rate_top: match");
		else
			$display("phase_to_complex_with_rate_top: mismatch");
		$finish;
	end
endmodule
